// ----- src/swpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_pkg
// Shared types and constants of the sliding window percentile tracker.
// ----------------------------------------------------------------------------
package swpt_pkg;

    localparam int P_WINDOW = 120;
    localparam int P_DW     = 32;
    localparam int P_LANES  = 3;

    // ceil(x / 100) = floor((x + 99) / 100); floor(y / 100) = (y * P_RECIP) >> P_SHIFT,
    // exact for y below about 199000 (covers WINDOW up to 1024)
    localparam int P_RND    = 99;
    localparam int P_RECIP  = 167773;
    localparam int P_RCP_W  = 18;
    localparam int P_SHIFT  = 24;

    localparam int P_PCT [P_LANES] = '{50, 90, 99};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_RANK,
        S_SCAN,
        S_BIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic write;
        logic mul1;
        logic mul2;
        logic rank;
        logic scan;
        logic bit_dec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic bit_last;
        logic out_busy;
    } t_sts;

    typedef struct packed {
        logic [P_DW-1:0] frames_seen;
        logic [P_DW-1:0] pct50;
        logic [P_DW-1:0] pct90;
        logic [P_DW-1:0] pct99;
        logic [P_DW-1:0] window_max;
    } t_result;

endpackage

// ----- src/swpt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_if
// Valid/ready channels: sample input and result output.
// ----------------------------------------------------------------------------
interface swpt_smp_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_us;
    modport source (output valid, output sample_us, input ready);
    modport sink   (input valid, input sample_us, output ready);
endinterface

interface swpt_res_if import swpt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/swpt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_ctrl
// Sequencer: write, rank setup, 32 radix passes over the window, output.
// ----------------------------------------------------------------------------
module swpt_ctrl import swpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_RANK;
            end
            S_RANK: begin
                o_cmd.rank = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                o_cmd.bit_dec = 1'b1;
                n_state       = i_sts.bit_last ? S_OUT : S_SCAN;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/swpt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_dp
// Sample ring, rank arithmetic, per-bit radix select counters, result register.
// ----------------------------------------------------------------------------
module swpt_dp import swpt_pkg::*; #(
    parameter int WINDOW = P_WINDOW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [P_DW-1:0] i_sample,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_result         o_out
);

    localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int NW = $clog2(WINDOW + 1);
    localparam int XW = NW + 7;
    localparam int PW = XW + P_RCP_W;
    localparam logic [AW-1:0] LAST_POS = AW'(WINDOW - 1);
    localparam logic [NW-1:0] N_FULL   = NW'(WINDOW);

    logic [P_DW-1:0] r_mem [WINDOW];
    logic [P_DW-1:0] r_rdata;
    logic            r_rvld;

    logic [AW-1:0]   r_pos;
    logic [P_DW-1:0] r_count;
    logic [NW-1:0]   r_n;
    logic [NW-1:0]   r_idx;
    logic [4:0]      r_bit;
    logic [P_DW-1:0] r_max;

    logic [XW-1:0]   r_x   [P_LANES];
    logic [PW-1:0]   r_p   [P_LANES];
    logic [NW-1:0]   r_k   [P_LANES];
    logic [NW-1:0]   r_cnt [P_LANES];
    logic [P_DW-1:0] r_pfx [P_LANES];
    logic [NW-1:0]   n_k   [P_LANES];

    logic            r_out_valid;
    t_result         r_out;

    logic [P_DW-1:0] w_mask;
    logic            w_issue;

    assign w_issue = i_cmd.scan && (r_idx < r_n);
    assign w_mask  = {P_DW{1'b1}} << ({1'b0, r_bit} + 6'd1);

    // rank = min(n-1, ceil(n*p/100)-1)
    always_comb begin
        logic [PW-1:0] t;
        logic [NW-1:0] nm1;
        nm1 = r_n - NW'(1);
        for (int j = 0; j < P_LANES; j++) begin
            t      = (r_p[j] >> P_SHIFT) - PW'(1);
            n_k[j] = (t > PW'(nm1)) ? nm1 : NW'(t);
        end
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_pos] <= i_sample;
        end
        if (w_issue) begin
            r_rdata <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_count     <= '0;
            r_n         <= '0;
            r_idx       <= '0;
            r_rvld      <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_pos <= (r_pos >= LAST_POS) ? '0 : r_pos + AW'(1);
                if (r_count != {P_DW{1'b1}}) begin
                    r_count <= r_count + P_DW'(1);
                end
                if (r_n != N_FULL) begin
                    r_n <= r_n + NW'(1);
                end
            end
            if (i_cmd.rank || i_cmd.bit_dec) begin
                r_idx  <= '0;
                r_rvld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rvld <= w_issue;
                if (w_issue) begin
                    r_idx <= r_idx + NW'(1);
                end
            end
            if (i_cmd.rank) begin
                r_bit <= 5'd31;
            end else if (i_cmd.bit_dec) begin
                r_bit <= r_bit - 5'd1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lane arithmetic and radix select
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < P_LANES; j++) begin
            if (i_cmd.mul1) begin
                r_x[j] <= XW'(r_n) * XW'(P_PCT[j]) + XW'(P_RND);
            end
            if (i_cmd.mul2) begin
                r_p[j] <= PW'(r_x[j]) * PW'(P_RECIP);
            end
            if (i_cmd.rank) begin
                r_k[j]   <= n_k[j];
                r_pfx[j] <= '0;
                r_cnt[j] <= '0;
            end else if (i_cmd.bit_dec) begin
                r_cnt[j] <= '0;
                if (r_k[j] >= r_cnt[j]) begin
                    r_pfx[j][r_bit] <= 1'b1;
                    r_k[j]          <= r_k[j] - r_cnt[j];
                end
            end else if (r_rvld) begin
                // count samples that share the prefix and have a zero here
                if ((((r_rdata ^ r_pfx[j]) & w_mask) == '0) && !r_rdata[r_bit]) begin
                    r_cnt[j] <= r_cnt[j] + NW'(1);
                end
            end
        end
        if (i_cmd.rank) begin
            r_max <= '0;
        end else if (r_rvld && (r_rdata > r_max)) begin
            r_max <= r_rdata;
        end
        if (i_cmd.out_load) begin
            r_out.frames_seen <= r_count;
            r_out.pct50       <= r_pfx[0];
            r_out.pct90       <= r_pfx[1];
            r_out.pct99       <= r_pfx[2];
            r_out.window_max  <= r_max;
        end
    end

    assign o_sts.scan_done = (r_idx == r_n) && !r_rvld;
    assign o_sts.bit_last  = (r_bit == 5'd0);
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

// ----- src/sliding_window_percentile_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_percentile_tracker
// Ring of the last WINDOW frame times; per item returns the total count,
// nearest-rank p50/p90/p99 and the window maximum.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                   handshake
//  i_smp     in    sample_us                                 valid/ready
//  o_res     out   frames_seen pct50 pct90 pct99 window_max  valid/ready
//
//  Each radix-select pass covers the n = min(count, WINDOW) stored samples,
//  one pass per result bit, each reading the ring once through its single
//  read port; a new sample is taken only when the sequencer is idle.
//  Reset (i_rst_n low, synchronous) clears write position, count and the
//  sequencer; ring contents are only read once written.
//  A result waits in the output register; the next item is taken meanwhile,
//  and only the final load stalls if the previous result is still held.
// ----------------------------------------------------------------------------
module sliding_window_percentile_tracker import swpt_pkg::*; #(
    parameter int WINDOW = P_WINDOW
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swpt_smp_if.sink   i_smp,
    swpt_res_if.source o_res
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    logic    w_in_ready;
    logic    w_out_valid;
    t_result w_out;

    // sequencer: idle -> write -> rank setup -> 32 x (scan, decide) -> out
    swpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // ring, three rank lanes resolved one bit per pass from MSB down
    swpt_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_smp.sample_us),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .o_out       (w_out)
    );

    assign i_smp.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_out;

endmodule

// ----- src/swpt_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpt_chk
// Port-level checks of the percentile tracker, bound to the top level.
// ----------------------------------------------------------------------------
module swpt_chk import swpt_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_out
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("stalled result changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out.pct50 <= i_out.pct90) && (i_out.pct90 <= i_out.pct99)
                        && (i_out.pct99 <= i_out.window_max))
        else $error("percentiles out of order");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.frames_seen != '0)
        else $error("result with zero count");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while busy");

endmodule

bind sliding_window_percentile_tracker swpt_chk u_swpt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out       (o_res.data)
);
